// ----- rtl/bpa_pkg.sv -----
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

	localparam int ADDR_W = 28;
	localparam int CNT_W = 17;
	localparam int HP_W = 16;
	localparam int WORD_W = 32;
	localparam int WBIT_W = 5;
	localparam int MAP_PAGES_MAX = 65536;
	localparam int DEF_PAGE_COUNT = 65536;
	localparam int DEF_PAGE_BITS = 12;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [HP_W-1:0] HP_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_ADD     = 2'd2,
		CMD_RESERVE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OOM       = 3'd1,
		ST_NULL      = 3'd2,
		ST_UNALIGNED = 3'd3,
		ST_RANGE     = 3'd4,
		ST_DOUBLE    = 3'd5
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] page_addr;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] alloc_addr;
		logic [CNT_W-1:0]  free_count;
		logic [CNT_W-1:0]  used_count;
	} out_t;

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] c);
		return (c == '0) ? '0 : c - 1'b1;
	endfunction

endpackage

// ----- rtl/bitmap_page_allocator_core.sv -----
// Top level of the first-fit bitmap page allocator.
//
// Commands arrive on in_valid/in_ready with in_data (cmd, page_addr); each
// gives exactly one result beat on out_valid/out_ready with out_data (status,
// alloc_addr, free_count, used_count). The page limit register is written through
// cfg_we/cfg_wdata; the user must do so only while the block is idle, as the
// block itself does not enforce this. It takes effect at once. The used bitmap
// lives in one synchronous RAM of 32-bit words, one read and one write port,
// with a registered read. Free, add usable and reserve: a failing address check
// goes from accept through S_DONE to the result register, a valid page first
// through a read-modify-write in S_RMW. Allocate streams the map one word per
// cycle from word 0, up to the word that holds the page limit.
// One command is in flight at a time; the next is accepted as soon as the
// previous result sits in the output register, even if the receiver stalls.
// A stalled receiver holds the output beat and, once a second result is
// ready, holds the block until the first beat is taken.
// After reset every page reads as used and all counters are zero; a clearing
// pass in S_CLEAR fills every RAM word with ones, and in_ready stays low
// until it ends.
module bitmap_page_allocator_core #(
	parameter int PAGE_COUNT = bpa_pkg::DEF_PAGE_COUNT,
	parameter int PAGE_BITS  = bpa_pkg::DEF_PAGE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bpa_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bpa_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [bpa_pkg::HP_W-1:0]  cfg_wdata
);

	localparam int MAP_PAGES = (PAGE_COUNT < bpa_pkg::MAP_PAGES_MAX) ?
		PAGE_COUNT : bpa_pkg::MAP_PAGES_MAX;
	localparam int WORDS = (MAP_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
	localparam int WADDR_W = $clog2(WORDS);
	localparam int PG_W = WADDR_W + bpa_pkg::WBIT_W;
	localparam logic [bpa_pkg::HP_W-1:0] MAX_PG = bpa_pkg::HP_W'(MAP_PAGES - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RMW,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [WADDR_W-1:0]           clr_q;
	logic [bpa_pkg::HP_W-1:0]     hp_q;
	bpa_pkg::cmd_t                cmd_q;
	logic [PG_W-1:0]              pg_q;
	logic [WADDR_W-1:0]           word_s1;
	bpa_pkg::status_t             res_status_q;
	logic [bpa_pkg::ADDR_W-1:0]   res_addr_q;
	logic [bpa_pkg::CNT_W-1:0]    free_q;
	logic [bpa_pkg::CNT_W-1:0]    used_q;
	logic [bpa_pkg::CNT_W-1:0]    usable_q;
	logic                         out_valid_q;
	bpa_pkg::out_t                out_q;

	logic [bpa_pkg::WORD_W-1:0]   mem [WORDS];
	logic [bpa_pkg::WORD_W-1:0]   rd_data;
	logic                         mem_we;
	logic [WADDR_W-1:0]           mem_wa;
	logic [bpa_pkg::WORD_W-1:0]   mem_wd;
	logic [WADDR_W-1:0]           mem_ra;

	logic [bpa_pkg::HP_W-1:0]     lim;
	logic [WADDR_W-1:0]           lim_word;
	logic [bpa_pkg::WORD_W-1:0]   tail_mask;
	logic [bpa_pkg::WORD_W-1:0]   free_bits;
	logic                         found;
	logic [bpa_pkg::WBIT_W-1:0]   found_bit;
	logic                         in_hs;
	logic [PG_W-1:0]              in_pg;
	bpa_pkg::status_t             in_err;
	logic                         in_bad;
	logic                         cur_used;
	logic [bpa_pkg::WORD_W-1:0]   pg_onehot;

	assign lim = (hp_q > MAX_PG) ? MAX_PG : hp_q;
	assign lim_word = lim[PG_W-1:bpa_pkg::WBIT_W];
	assign in_ready = (state_q == S_IDLE);
	assign in_hs = in_valid && in_ready;
	assign in_pg = PG_W'(in_data.page_addr >> PAGE_BITS);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		in_bad = 1'b1;
		in_err = bpa_pkg::ST_OK;
		if (in_data.cmd == bpa_pkg::CMD_FREE && in_data.page_addr == '0) begin
			in_err = bpa_pkg::ST_NULL;
		end else if (in_data.page_addr[PAGE_BITS-1:0] != '0) begin
			in_err = bpa_pkg::ST_UNALIGNED;
		end else if ((in_data.page_addr >> PAGE_BITS) > bpa_pkg::ADDR_W'(lim)) begin
			in_err = bpa_pkg::ST_RANGE;
		end else begin
			in_bad = 1'b0;
		end
	end

	always_comb begin
		tail_mask = '1;
		if (word_s1 == lim_word) begin
			tail_mask = {bpa_pkg::WORD_W{1'b1}} >> (5'd31 - lim[bpa_pkg::WBIT_W-1:0]);
		end
		free_bits = ~rd_data & tail_mask;
		found = |free_bits;
		found_bit = '0;
		for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				found_bit = bpa_pkg::WBIT_W'(i);
			end
		end
	end

	assign cur_used = rd_data[pg_q[bpa_pkg::WBIT_W-1:0]];
	assign pg_onehot = bpa_pkg::WORD_W'(1) << pg_q[bpa_pkg::WBIT_W-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pg_q[PG_W-1:bpa_pkg::WBIT_W];
		mem_wd = rd_data;
		mem_ra = word_s1 + 1'b1;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '1;
			end
			S_IDLE: begin
				mem_ra = (in_data.cmd == bpa_pkg::CMD_ALLOC) ? '0 :
					in_pg[PG_W-1:bpa_pkg::WBIT_W];
			end
			S_SCAN: begin
				mem_we = found;
				mem_wa = word_s1;
				mem_wd = rd_data | (bpa_pkg::WORD_W'(1) << found_bit);
			end
			S_RMW: begin
				case (cmd_q)
					bpa_pkg::CMD_FREE, bpa_pkg::CMD_ADD: begin
						mem_we = cur_used;
						mem_wd = rd_data & ~pg_onehot;
					end
					bpa_pkg::CMD_RESERVE: begin
						mem_we = !cur_used;
						mem_wd = rd_data | pg_onehot;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= bpa_pkg::HP_RESET;
		end else if (cfg_we) begin
			hp_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cmd_q <= bpa_pkg::CMD_ALLOC;
			pg_q <= '0;
			word_s1 <= '0;
			res_status_q <= bpa_pkg::ST_OK;
			res_addr_q <= '0;
			free_q <= '0;
			used_q <= '0;
			usable_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WADDR_W'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_hs) begin
						cmd_q <= in_data.cmd;
						pg_q <= in_pg;
						word_s1 <= '0;
						res_addr_q <= '0;
						res_status_q <= bpa_pkg::ST_OK;
						if (in_data.cmd == bpa_pkg::CMD_ALLOC) begin
							state_q <= S_SCAN;
						end else if (in_bad) begin
							res_status_q <= in_err;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RMW;
						end
					end
				end
				S_SCAN: begin
					word_s1 <= word_s1 + 1'b1;
					if (found) begin
						used_q <= bpa_pkg::inc_sat(used_q);
						free_q <= bpa_pkg::dec_sat(free_q);
						res_addr_q <= bpa_pkg::ADDR_W'({word_s1, found_bit}) << PAGE_BITS;
						state_q <= S_DONE;
					end else if (word_s1 == lim_word) begin
						res_status_q <= bpa_pkg::ST_OOM;
						state_q <= S_DONE;
					end
				end
				S_RMW: begin
					case (cmd_q)
						bpa_pkg::CMD_FREE: begin
							if (cur_used) begin
								used_q <= bpa_pkg::dec_sat(used_q);
								free_q <= bpa_pkg::inc_sat(free_q);
							end else begin
								res_status_q <= bpa_pkg::ST_DOUBLE;
							end
						end
						bpa_pkg::CMD_ADD: begin
							if (cur_used) begin
								usable_q <= bpa_pkg::inc_sat(usable_q);
								free_q <= bpa_pkg::inc_sat(free_q);
							end
						end
						bpa_pkg::CMD_RESERVE: begin
							if (!cur_used) begin
								free_q <= bpa_pkg::dec_sat(free_q);
								used_q <= bpa_pkg::inc_sat(used_q);
							end
						end
						default: begin
							res_status_q <= bpa_pkg::ST_OK;
						end
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.status <= res_status_q;
						out_q.alloc_addr <= res_addr_q;
						out_q.free_count <= free_q;
						out_q.used_count <= used_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

endmodule

// ----- rtl/bpa_checker.sv -----
// Port-level checks for the bitmap page allocator, bound to the top level.
module bpa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input bpa_pkg::out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while one is in flight");

	a_addr_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != bpa_pkg::ST_OK |-> out_data.alloc_addr == '0)
		else $error("address returned with a failing status");

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);

// ----- sim/tb.sv -----
// Self-checking testbench for the first-fit bitmap page allocator core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES = bpa_pkg::DEF_PAGE_COUNT;
	localparam int PG_BITS = bpa_pkg::DEF_PAGE_BITS;

	class frame_ledger;
		bit used_map [PAGES];
		logic [bpa_pkg::CNT_W-1:0] spare_pages;
		logic [bpa_pkg::CNT_W-1:0] busy_pages;
		logic [bpa_pkg::CNT_W-1:0] usable_pages;
		logic [bpa_pkg::HP_W-1:0] top_page;
		bpa_pkg::out_t pending_results [$];
		int fails;

		function new();
			foreach (used_map[i])
				used_map[i] = 1'b1;
			spare_pages = '0;
			busy_pages = '0;
			usable_pages = '0;
			top_page = bpa_pkg::HP_RESET;
			fails = 0;
		endfunction

		function void set_top(logic [bpa_pkg::HP_W-1:0] v);
			top_page = v;
		endfunction

		function logic [bpa_pkg::CNT_W-1:0] up(logic [bpa_pkg::CNT_W-1:0] c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		function logic [bpa_pkg::CNT_W-1:0] down(logic [bpa_pkg::CNT_W-1:0] c);
			return (c == '0) ? c : c - 1'b1;
		endfunction

		function void note_cmd(bpa_pkg::in_t d);
			bpa_pkg::out_t r;
			int lim;
			int pg;
			bit hit;
			lim = (int'(top_page) > PAGES - 1) ? PAGES - 1 : int'(top_page);
			pg = int'(d.page_addr >> PG_BITS);
			hit = 1'b0;
			r.status = bpa_pkg::ST_OK;
			r.alloc_addr = '0;
			if (d.cmd == bpa_pkg::CMD_ALLOC) begin
				for (int i = 0; i <= lim && !hit; i++) begin
					if (!used_map[i]) begin
						hit = 1'b1;
						pg = i;
					end
				end
				if (hit) begin
					used_map[pg] = 1'b1;
					busy_pages = up(busy_pages);
					spare_pages = down(spare_pages);
					r.alloc_addr = bpa_pkg::ADDR_W'(pg << PG_BITS);
				end else begin
					r.status = bpa_pkg::ST_OOM;
				end
			end else if (d.cmd == bpa_pkg::CMD_FREE && d.page_addr == '0) begin
				r.status = bpa_pkg::ST_NULL;
			end else if (d.page_addr[PG_BITS-1:0] != '0) begin
				r.status = bpa_pkg::ST_UNALIGNED;
			end else if (pg > lim) begin
				r.status = bpa_pkg::ST_RANGE;
			end else begin
				case (d.cmd)
					bpa_pkg::CMD_FREE: begin
						if (!used_map[pg]) begin
							r.status = bpa_pkg::ST_DOUBLE;
						end else begin
							used_map[pg] = 1'b0;
							busy_pages = down(busy_pages);
							spare_pages = up(spare_pages);
						end
					end
					bpa_pkg::CMD_ADD: begin
						if (used_map[pg]) begin
							used_map[pg] = 1'b0;
							usable_pages = up(usable_pages);
							spare_pages = up(spare_pages);
						end
					end
					bpa_pkg::CMD_RESERVE: begin
						if (!used_map[pg]) begin
							used_map[pg] = 1'b1;
							spare_pages = down(spare_pages);
							busy_pages = up(busy_pages);
						end
					end
					default: ;
				endcase
			end
			r.free_count = spare_pages;
			r.used_count = busy_pages;
			pending_results.push_back(r);
		endfunction

		function void check_result(bpa_pkg::out_t got);
			bpa_pkg::out_t want;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d addr %h",
					got.status, got.alloc_addr);
				fails++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fails++;
			end
			if (got.alloc_addr !== want.alloc_addr) begin
				$error("alloc_addr: expected %h, got %h", want.alloc_addr, got.alloc_addr);
				fails++;
			end
			if (got.free_count !== want.free_count) begin
				$error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
				fails++;
			end
			if (got.used_count !== want.used_count) begin
				$error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bpa_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bpa_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [bpa_pkg::HP_W-1:0] cfg_wdata = '0;

	bit calm = 1'b0;
	frame_ledger book = new();

	bitmap_page_allocator_core dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_we,
		.cfg_wdata
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready)
				book.check_result(out_data);
			out_ready <= calm || ($urandom_range(0, 99) >= 33);
		end
	end

	task automatic send_cmd(input bpa_pkg::cmd_t c, input logic [bpa_pkg::ADDR_W-1:0] a);
		bpa_pkg::in_t d;
		d.cmd = c;
		d.page_addr = a;
		while (!calm && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		book.note_cmd(d);
	endtask

	task automatic send_random(input int lim);
		bpa_pkg::cmd_t c;
		logic [bpa_pkg::ADDR_W-1:0] a;
		int roll;
		int span;
		int pg;
		roll = $urandom_range(0, 99);
		a = bpa_pkg::ADDR_W'($urandom_range(0, (1 << bpa_pkg::ADDR_W) - 1));
		span = (lim < 63) ? lim : 63;
		if ($urandom_range(0, 3) == 0)
			pg = int'($urandom_range(lim - span, lim));
		else
			pg = int'($urandom_range(0, span));
		if (roll < 30)
			c = bpa_pkg::CMD_ALLOC;
		else if (roll < 60)
			c = bpa_pkg::CMD_FREE;
		else if (roll < 85)
			c = bpa_pkg::CMD_ADD;
		else
			c = bpa_pkg::CMD_RESERVE;
		roll = $urandom_range(0, 99);
		if (c != bpa_pkg::CMD_ALLOC && roll >= 10) begin
			if (roll < 14)
				a = '0;
			else if (roll < 20 && lim < PAGES - 1)
				a = bpa_pkg::ADDR_W'($urandom_range(lim + 1, PAGES - 1) << PG_BITS);
			else
				a = bpa_pkg::ADDR_W'(pg << PG_BITS);
		end
		send_cmd(c, a);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (book.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_top_page(input logic [bpa_pkg::HP_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.set_top(v);
	endtask

	initial begin
		int tops [6];
		tops = '{0, 37, 255, 1000, 65535, 130};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every page starts used, so the first allocate runs dry
		send_cmd(bpa_pkg::CMD_ALLOC, 28'h0000000);
		send_cmd(bpa_pkg::CMD_FREE, 28'h0000000);
		send_cmd(bpa_pkg::CMD_FREE, 28'h0000001);
		send_cmd(bpa_pkg::CMD_RESERVE, 28'hFFFFFFF);
		send_cmd(bpa_pkg::CMD_ADD, 28'h0000800);
		send_cmd(bpa_pkg::CMD_ADD, 28'h0000000);
		send_cmd(bpa_pkg::CMD_ADD, 28'h0000000);
		send_cmd(bpa_pkg::CMD_RESERVE, 28'hFFFF000);
		send_cmd(bpa_pkg::CMD_ADD, 28'hFFFF000);
		send_cmd(bpa_pkg::CMD_ALLOC, 28'hFFFFFFF);
		send_cmd(bpa_pkg::CMD_ALLOC, 28'h0000000);
		send_cmd(bpa_pkg::CMD_ALLOC, 28'h0000000);
		send_cmd(bpa_pkg::CMD_FREE, 28'h0000000);
		send_cmd(bpa_pkg::CMD_FREE, 28'hFFFF000);
		send_cmd(bpa_pkg::CMD_FREE, 28'hFFFF000);
		send_cmd(bpa_pkg::CMD_RESERVE, 28'hFFFF000);
		// free pages that were never usable: used count bottoms out at zero
		send_cmd(bpa_pkg::CMD_FREE, 28'h0005000);
		send_cmd(bpa_pkg::CMD_FREE, 28'h0006000);
		send_cmd(bpa_pkg::CMD_FREE, 28'h0007000);
		send_cmd(bpa_pkg::CMD_ALLOC, 28'h0000000);

		foreach (tops[p]) begin
			drain();
			calm = (tops[p] == 255);
			write_top_page(bpa_pkg::HP_W'(tops[p]));
			if (tops[p] == 0) begin
				send_cmd(bpa_pkg::CMD_ADD, 28'h0001000);
				send_cmd(bpa_pkg::CMD_FREE, 28'h0001000);
				send_cmd(bpa_pkg::CMD_ALLOC, 28'h0000000);
				send_cmd(bpa_pkg::CMD_ADD, 28'h0000000);
				send_cmd(bpa_pkg::CMD_ALLOC, 28'h0000000);
			end
			for (int n = 0; n < 45; n++)
				send_random(tops[p]);
		end

		drain();
		repeat (20) @(posedge clk);
		if (book.fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/bpa_pkg.sv
rtl/bitmap_page_allocator_core.sv
rtl/bpa_checker.sv
sim/tb.sv
